// File: design/dpsa_pkg.sv
// ----------------------------------------------------------------------------
// dpsa_pkg
// Shared types and constants of the delta arm position-to-servo-angle block.
// ----------------------------------------------------------------------------
`default_nettype none

package dpsa_pkg;

    // Register map of the configuration port
    localparam logic [1:0] REG_LIMIT_X = 2'd0;
    localparam logic [1:0] REG_LIMIT_Y = 2'd1;
    localparam logic [1:0] REG_LIMIT_Z = 2'd2;

    // Field widths
    localparam int COORD_W = 16;
    localparam int LIMIT_W = 15;
    localparam int ANGLE_W = 8;
    localparam int CFG_ADDR_W = 2;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 15'd100;

    // Mapping divider: dividend is coordinate * span, quotient is at most 200
    localparam int NUM_W = 23;
    localparam int QUO_W = 8;
    localparam logic [7:0] SPAN_XY = 8'd200;
    localparam logic [7:0] SPAN_Z = 8'd100;
    localparam logic [7:0] MM_OFFSET = 8'd100;

    // base = (zq * 60) / 100 + 60 = floor(zq * 615 / 1024) + 60 for zq < 342
    localparam int BASE_RECIP = 615;
    localparam int BASE_SHIFT = 10;
    localparam logic [7:0] BASE_OFFSET = 8'd60;

    // Servo range
    localparam int SERVO_LO = 30;
    localparam int SERVO_HI = 150;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_RANGE = 2'd1,
        STATUS_SERVO = 2'd2
    } status_t;

    // One result beat, status in the lowest bits
    typedef struct packed {
        logic [ANGLE_W-1:0] angle_three;
        logic [ANGLE_W-1:0] angle_two;
        logic [ANGLE_W-1:0] angle_one;
        status_t            status;
    } dpsa_result_t;

endpackage

`default_nettype wire

// File: design/delta_position_to_servo_angles_unit.sv
// ----------------------------------------------------------------------------
// delta_position_to_servo_angles_unit
// Grid target to three delta arm servo angles, limit check and clamping.
// ----------------------------------------------------------------------------
//   channel   dir  handshake          payload
//   s_*       in   tvalid/tready      tdata: target_x, target_y, target_z
//   m_*       out  tvalid/tready      tdata: status, angle_one/two/three
//   cfg_*     in   cfg_wr_en          cfg_addr, cfg_wdata (limit_x/y/z)
//
// One target per cycle while the skid entry is free; from input beat to output
// beat a target passes the input register, the 8-stage mapping divider,
// 4 angle stages and the output register.
// Reset clears valid bits and loads all limits with 100; no warm-up.
// A stalled output holds the pipeline once the skid entry is full;
// s_tready depends only on registered state.
// ----------------------------------------------------------------------------
`default_nettype none

module delta_position_to_servo_angles_unit
    import dpsa_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // target_x [15:0], target_y [31:16], target_z [47:32]
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [47:0]           s_tdata,
    // status [1:0], angle_one [9:2], angle_two [17:10], angle_three [25:18]
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [31:0]                m_tdata,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [LIMIT_W-1:0]    cfg_wdata
);

    logic [LIMIT_W-1:0] limit_x_reg;
    logic [LIMIT_W-1:0] limit_y_reg;
    logic [LIMIT_W-1:0] limit_z_reg;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_x_reg <= LIMIT_RESET;
            limit_y_reg <= LIMIT_RESET;
            limit_z_reg <= LIMIT_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                REG_LIMIT_X: limit_x_reg <= cfg_wdata;
                REG_LIMIT_Y: limit_y_reg <= cfg_wdata;
                REG_LIMIT_Z: limit_z_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    logic adv;

    // Input stage: limit check and dividends
    logic signed [COORD_W-1:0] tx;
    logic signed [COORD_W-1:0] ty;
    logic signed [COORD_W-1:0] tz;
    logic                      oor;
    logic                      s0_vld_reg;
    logic                      s0_oor_reg;
    logic [NUM_W-1:0]          s0_nx_reg;
    logic [NUM_W-1:0]          s0_ny_reg;
    logic [NUM_W-1:0]          s0_nz_reg;

    assign tx = s_tdata[15:0];
    assign ty = s_tdata[31:16];
    assign tz = s_tdata[47:32];

    assign oor = tx[COORD_W-1] || (tx[LIMIT_W-1:0] > limit_x_reg) ||
                 ty[COORD_W-1] || (ty[LIMIT_W-1:0] > limit_y_reg) ||
                 tz[COORD_W-1] || (tz[LIMIT_W-1:0] > limit_z_reg);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s0_oor_reg <= oor;
            s0_nx_reg  <= NUM_W'(tx[LIMIT_W-1:0]) * NUM_W'(SPAN_XY);
            s0_ny_reg  <= NUM_W'(ty[LIMIT_W-1:0]) * NUM_W'(SPAN_XY);
            s0_nz_reg  <= NUM_W'(tz[LIMIT_W-1:0]) * NUM_W'(SPAN_Z);
        end
    end

    // Mapping dividers
    logic [QUO_W-1:0] qx_div;
    logic [QUO_W-1:0] qy_div;
    logic [QUO_W-1:0] qz_div;
    logic [QUO_W-1:0] qx;
    logic [QUO_W-1:0] qy;
    logic [QUO_W-1:0] qz;

    dpsa_divider u_div_x (
        .clk   (clk),
        .en    (adv),
        .numer (s0_nx_reg),
        .denom (limit_x_reg),
        .quot  (qx_div)
    );

    dpsa_divider u_div_y (
        .clk   (clk),
        .en    (adv),
        .numer (s0_ny_reg),
        .denom (limit_y_reg),
        .quot  (qy_div)
    );

    dpsa_divider u_div_z (
        .clk   (clk),
        .en    (adv),
        .numer (s0_nz_reg),
        .denom (limit_z_reg),
        .quot  (qz_div)
    );

    // Zero limit maps the axis to its low end
    assign qx = (limit_x_reg == '0) ? '0 : qx_div;
    assign qy = (limit_y_reg == '0) ? '0 : qy_div;
    assign qz = (limit_z_reg == '0) ? '0 : qz_div;

    // Valid and range flag alongside the divider stages
    logic [QUO_W-1:0] dv_vld_reg;
    logic [QUO_W-1:0] dv_oor_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_vld_reg <= 1'b0;
            dv_vld_reg <= '0;
        end
        else if (adv)
        begin
            s0_vld_reg <= s_tvalid;
            dv_vld_reg <= {dv_vld_reg[QUO_W-2:0], s0_vld_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dv_oor_reg <= {dv_oor_reg[QUO_W-2:0], s0_oor_reg};
        end
    end

    // Angle pipeline
    logic         ang_vld;
    dpsa_result_t ang_res;

    dpsa_angles #(
        .FRAC_BITS (FRAC_BITS)
    ) u_angles (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (adv),
        .in_valid   (dv_vld_reg[QUO_W-1]),
        .in_oor     (dv_oor_reg[QUO_W-1]),
        .qx         (qx),
        .qy         (qy),
        .qz         (qz),
        .out_valid  (ang_vld),
        .out_result (ang_res)
    );

    // Output register and skid entry
    dpsa_result_t head;

    dpsa_out_buf u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (ang_vld && adv),
        .push_data (ang_res),
        .space     (adv),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .head      (head)
    );

    assign s_tready = adv;
    assign m_tdata  = {6'b0, head};

endmodule

`default_nettype wire

// File: design/dpsa_divider.sv
// ----------------------------------------------------------------------------
// dpsa_divider
// Pipelined restoring divider, one quotient bit per stage, MSB first.
// Dividend must be below denom * 2^QUO_W.
// ----------------------------------------------------------------------------
`default_nettype none

module dpsa_divider
    import dpsa_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               en,
    input  wire logic [NUM_W-1:0]   numer,
    input  wire logic [LIMIT_W-1:0] denom,
    output logic      [QUO_W-1:0]   quot
);

    logic [NUM_W-1:0] rem_reg [0:QUO_W-2];
    logic [QUO_W-1:0] quo_reg [0:QUO_W-1];

    for (genvar i = 0; i < QUO_W; i++) begin : g_stage
        logic [NUM_W-1:0] rem_in;
        logic [NUM_W-1:0] dsh;
        logic             take;
        logic [QUO_W-1:0] quo_in;
        logic [QUO_W-1:0] quo_next;

        if (i == 0) begin : g_first
            assign rem_in = numer;
            assign quo_in = '0;
        end
        else begin : g_rest
            assign rem_in = rem_reg[i-1];
            assign quo_in = quo_reg[i-1];
        end

        // Divisor aligned to this stage's quotient bit
        assign dsh = NUM_W'(denom) << (QUO_W - 1 - i);

        // Trial subtract
        assign take     = (rem_in >= dsh);
        assign quo_next = take ? (quo_in | (QUO_W'(1) << (QUO_W - 1 - i))) : quo_in;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                quo_reg[i] <= quo_next;
            end
        end

        // Last stage keeps no remainder
        if (i < QUO_W - 1) begin : g_rem
            logic [NUM_W-1:0] rem_next;

            assign rem_next = take ? (rem_in - dsh) : rem_in;

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[i] <= rem_next;
                end
            end
        end
    end

    assign quot = quo_reg[QUO_W-1];

endmodule

`default_nettype wire

// File: design/dpsa_angles.sv
// ----------------------------------------------------------------------------
// dpsa_angles
// Four-stage angle pipeline: millimetre offsets and base angle, fixed-point
// products, theta sums, truncate/clamp/status.
// ----------------------------------------------------------------------------
`default_nettype none

module dpsa_angles
    import dpsa_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             en,
    input  wire logic             in_valid,
    input  wire logic             in_oor,
    input  wire logic [QUO_W-1:0] qx,
    input  wire logic [QUO_W-1:0] qy,
    input  wire logic [QUO_W-1:0] qz,
    output logic                  out_valid,
    output dpsa_result_t          out_result
);

    // Theta holds up to 511 integer degrees plus sign
    localparam int TW = FRAC_BITS + 10;
    localparam int AW = TW - FRAC_BITS;

    localparam longint unsigned One = 64'd1 << FRAC_BITS;
    localparam longint unsigned CoFifth = (One * 64'd2 + 64'd5) / 64'd10;
    localparam longint unsigned CoTenth = (One + 64'd5) / 64'd10;
    localparam longint unsigned CoRoot =
        (One * 64'd173205080757 + 64'd500000000000) / 64'd1000000000000;

    localparam logic signed [TW-1:0] CO_FIFTH = TW'(CoFifth);
    localparam logic signed [TW-1:0] CO_TENTH = TW'(CoTenth);
    localparam logic signed [TW-1:0] CO_ROOT  = TW'(CoRoot);
    localparam logic signed [TW-1:0] TH_LO = TW'(SERVO_LO) <<< FRAC_BITS;
    localparam logic signed [TW-1:0] TH_HI = TW'(SERVO_HI) <<< FRAC_BITS;

    localparam int BP_W = QUO_W + BASE_SHIFT;

    // ---------------- stage A: millimetres and base angle ----------------
    logic                  a_vld_reg;
    logic                  a_oor_reg;
    logic signed [QUO_W:0] a_xm_reg;
    logic signed [QUO_W:0] a_ym_reg;
    logic [QUO_W-1:0]      a_base_reg;
    logic [BP_W-1:0]       base_prod;

    assign base_prod = BP_W'(qz) * BP_W'(BASE_RECIP);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_xm_reg   <= $signed({1'b0, qx}) - $signed({1'b0, MM_OFFSET});
            a_ym_reg   <= $signed({1'b0, qy}) - $signed({1'b0, MM_OFFSET});
            a_base_reg <= QUO_W'(base_prod >> BASE_SHIFT) + BASE_OFFSET;
            a_oor_reg  <= in_oor;
        end
    end

    // ---------------- stage B: fixed-point products ----------------
    logic                 b_vld_reg;
    logic                 b_oor_reg;
    logic signed [TW-1:0] b_bfx_reg;
    logic signed [TW-1:0] b_p5_reg;
    logic signed [TW-1:0] b_p10_reg;
    logic signed [TW-1:0] b_pr_reg;
    logic signed [TW-1:0] xm_w;
    logic signed [TW-1:0] ym_w;

    assign xm_w = TW'(a_xm_reg);
    assign ym_w = TW'(a_ym_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_bfx_reg <= $signed(TW'(a_base_reg)) <<< FRAC_BITS;
            b_p5_reg  <= xm_w * CO_FIFTH;
            b_p10_reg <= xm_w * CO_TENTH;
            b_pr_reg  <= ym_w * CO_ROOT;
            b_oor_reg <= a_oor_reg;
        end
    end

    // ---------------- stage C: theta sums ----------------
    logic                 c_vld_reg;
    logic                 c_oor_reg;
    logic signed [TW-1:0] c_t1_reg;
    logic signed [TW-1:0] c_t2_reg;
    logic signed [TW-1:0] c_t3_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_t1_reg  <= b_bfx_reg + b_p5_reg;
            c_t2_reg  <= b_bfx_reg - b_p10_reg + b_pr_reg;
            c_t3_reg  <= b_bfx_reg - b_p10_reg - b_pr_reg;
            c_oor_reg <= b_oor_reg;
        end
    end

    // ---------------- stage D: truncate, clamp, status ----------------
    logic                 d_vld_reg;
    dpsa_result_t         d_res_reg;
    dpsa_result_t         d_res_next;
    logic signed [TW-1:0] th [0:2];
    logic [ANGLE_W-1:0]   ang [0:2];
    logic [2:0]           bad;

    assign th[0] = c_t1_reg;
    assign th[1] = c_t2_reg;
    assign th[2] = c_t3_reg;

    for (genvar k = 0; k < 3; k++) begin : g_fin
        logic signed [AW-1:0] whole;

        // Thetas below zero clamp to the servo low end, so floor matches truncation
        assign whole  = AW'(th[k] >>> FRAC_BITS);
        assign bad[k] = (th[k] < TH_LO) || (th[k] > TH_HI);

        always_comb
        begin
            if (whole < AW'(SERVO_LO))
            begin
                ang[k] = ANGLE_W'(SERVO_LO);
            end
            else if (whole > AW'(SERVO_HI))
            begin
                ang[k] = ANGLE_W'(SERVO_HI);
            end
            else
            begin
                ang[k] = ANGLE_W'(whole);
            end
        end
    end

    always_comb
    begin
        if (c_oor_reg)
        begin
            d_res_next.status      = STATUS_RANGE;
            d_res_next.angle_one   = '0;
            d_res_next.angle_two   = '0;
            d_res_next.angle_three = '0;
        end
        else
        begin
            d_res_next.status      = (|bad) ? STATUS_SERVO : STATUS_OK;
            d_res_next.angle_one   = ang[0];
            d_res_next.angle_two   = ang[1];
            d_res_next.angle_three = ang[2];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_res_reg <= d_res_next;
        end
    end

    // Valid bits of all four stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
            d_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            a_vld_reg <= in_valid;
            b_vld_reg <= a_vld_reg;
            c_vld_reg <= b_vld_reg;
            d_vld_reg <= c_vld_reg;
        end
    end

    assign out_valid  = d_vld_reg;
    assign out_result = d_res_reg;

endmodule

`default_nettype wire

// File: design/dpsa_out_buf.sv
// ----------------------------------------------------------------------------
// dpsa_out_buf
// Output register with one skid entry; the pipeline advances while the skid
// entry is free.
// ----------------------------------------------------------------------------
`default_nettype none

module dpsa_out_buf
    import dpsa_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         push,
    input  wire dpsa_result_t push_data,
    output logic              space,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output dpsa_result_t      head
);

    dpsa_result_t head_reg;
    dpsa_result_t skid_reg;
    logic         head_vld_reg;
    logic         skid_vld_reg;
    logic         pop;

    assign pop = head_vld_reg && m_tready;

    // Control: push only happens while the skid entry is empty
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_vld_reg <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else if (pop)
        begin
            head_vld_reg <= skid_vld_reg || push;
            skid_vld_reg <= 1'b0;
        end
        else if (push && head_vld_reg)
        begin
            skid_vld_reg <= 1'b1;
        end
        else if (push)
        begin
            head_vld_reg <= 1'b1;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            head_reg <= skid_vld_reg ? skid_reg : push_data;
        end
        else if (push && head_vld_reg)
        begin
            skid_reg <= push_data;
        end
        else if (push)
        begin
            head_reg <= push_data;
        end
    end

    assign space    = !skid_vld_reg;
    assign m_tvalid = head_vld_reg;
    assign head     = head_reg;

endmodule

`default_nettype wire

// File: design/dpsa_checker.sv
// ----------------------------------------------------------------------------
// dpsa_checker
// Port-level checks of the servo angle unit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module dpsa_checker
    import dpsa_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata
);

    logic [1:0] st;
    logic [7:0] a1;
    logic [7:0] a2;
    logic [7:0] a3;

    assign st = m_tdata[1:0];
    assign a1 = m_tdata[9:2];
    assign a2 = m_tdata[17:10];
    assign a3 = m_tdata[25:18];

    // Only defined status codes leave the block
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (st == STATUS_OK || st == STATUS_RANGE || st == STATUS_SERVO))
        else $error("undefined status code");

    // Rejected target carries zero angles
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && st == STATUS_RANGE) |-> (a1 == '0 && a2 == '0 && a3 == '0))
        else $error("nonzero angle on rejected target");

    // Accepted targets always give clamped angles
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && st != STATUS_RANGE) |->
            (a1 >= 8'(SERVO_LO) && a1 <= 8'(SERVO_HI) &&
             a2 >= 8'(SERVO_LO) && a2 <= 8'(SERVO_HI) &&
             a3 >= 8'(SERVO_LO) && a3 <= 8'(SERVO_HI)))
        else $error("angle outside servo range");

    // Input stalls only after an output stall
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(s_tready) |-> $past(m_tvalid && !m_tready))
        else $error("input stalled without output back-pressure");

    // A stalled result stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> m_tvalid)
        else $error("result dropped while stalled");

endmodule

bind delta_position_to_servo_angles_unit dpsa_checker u_dpsa_checker (.*);

`default_nettype wire

// File: tb/sv/delta_position_to_servo_angles_unit_test.sv
// ----------------------------------------------------------------------------
// delta_position_to_servo_angles_unit_test
// Drives grid targets into the servo angle unit under several limit settings
// and checks every result beat against an in-bench model of the kinematics or a typed-in result.
// ----------------------------------------------------------------------------
module delta_position_to_servo_angles_unit_test
    import dpsa_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC = 16;
    localparam int QUIET_LIMIT = 2000;
    localparam int PHASES = 7;
    localparam int ITEMS_PER_PHASE = 85;
    localparam int DRAIN_CYCLES = 20;

    // Fixed-point kinematics coefficients
    localparam longint FX_ONE = longint'(1) << FRAC;
    localparam longint COEF_FIFTH = (FX_ONE * 2 + 5) / 10;
    localparam longint COEF_TENTH = (FX_ONE + 5) / 10;
    localparam longint COEF_ROOT =
        (FX_ONE * 64'sd173205080757 + 64'sd500000000000) / 64'sd1000000000000;
    localparam longint MM_SPAN_XY = 200;
    localparam longint MM_SPAN_Z = 100;
    localparam longint MM_SHIFT = 100;
    localparam longint BASE_DEG = 60;

    // Results that can be typed in directly
    localparam dpsa_result_t NOT_TYPED = '0;
    localparam dpsa_result_t RANGE_FAULT =
        '{angle_three: 8'd0, angle_two: 8'd0, angle_one: 8'd0, status: STATUS_RANGE};
    localparam dpsa_result_t CENTER_HOME =
        '{angle_three: 8'd120, angle_two: 8'd120, angle_one: 8'd120, status: STATUS_OK};

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] z;
        logic               typed;
        dpsa_result_t       res;
    } target_row_t;

    // Directed targets, all under the reset limits of 100
    localparam int DIRECTED_ROWS = 18;
    localparam target_row_t DIRECTED [DIRECTED_ROWS] = '{
        '{16'd0,     16'd0,     16'd0,     1'b0, NOT_TYPED},   // lowest corner
        '{16'd100,   16'd100,   16'd100,   1'b0, NOT_TYPED},   // highest corner
        '{16'd50,    16'd50,    16'd100,   1'b1, CENTER_HOME},
        '{16'd50,    16'd50,    16'd0,     1'b0, NOT_TYPED},
        '{16'd100,   16'd0,     16'd50,    1'b0, NOT_TYPED},
        '{16'd0,     16'd100,   16'd50,    1'b0, NOT_TYPED},
        '{16'd100,   16'd100,   16'd0,     1'b0, NOT_TYPED},
        '{16'd0,     16'd0,     16'd100,   1'b0, NOT_TYPED},
        '{16'd33,    16'd67,    16'd99,    1'b0, NOT_TYPED},
        '{16'd1,     16'd99,    16'd1,     1'b0, NOT_TYPED},
        '{16'hFFFF,  16'd0,     16'd0,     1'b1, RANGE_FAULT}, // just below zero
        '{16'd0,     16'hFFFF,  16'd0,     1'b1, RANGE_FAULT},
        '{16'd0,     16'd0,     16'hFFFF,  1'b1, RANGE_FAULT},
        '{16'd101,   16'd0,     16'd0,     1'b1, RANGE_FAULT}, // just above limit
        '{16'd0,     16'd101,   16'd0,     1'b1, RANGE_FAULT},
        '{16'd0,     16'd0,     16'd101,   1'b1, RANGE_FAULT},
        '{16'h8000,  16'h8000,  16'h8000,  1'b1, RANGE_FAULT}, // most negative
        '{16'h7FFF,  16'h7FFF,  16'h7FFF,  1'b1, RANGE_FAULT}  // most positive
    };

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    // target_x [15:0], target_y [31:16], target_z [47:32]
    logic [47:0]           s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // status [1:0], angle_one [9:2], angle_two [17:10], angle_three [25:18]
    logic [31:0]           m_tdata;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = REG_LIMIT_X;
    logic [LIMIT_W-1:0]    cfg_wdata = '0;

    // Bench copy of the limit registers
    logic [LIMIT_W-1:0]    lim_x = LIMIT_RESET;
    logic [LIMIT_W-1:0]    lim_y = LIMIT_RESET;
    logic [LIMIT_W-1:0]    lim_z = LIMIT_RESET;

    dpsa_result_t          pending_angles [$];
    int                    mismatches = 0;
    int                    quiet_cycles = 0;
    bit                    steady = 1'b0;

    delta_position_to_servo_angles_unit #(
        .FRAC_BITS (FRAC)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    // 100 MHz clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Grid coordinate to its share of span, zero on a zero limit
    function automatic longint grid_to_span(input longint v, input longint span,
                                            input longint lim);
        return (lim == 0) ? 0 : (v * span) / lim;
    endfunction

    // Servo angles for one target under the current limits
    function automatic dpsa_result_t servo_angles_for(input logic [COORD_W-1:0] tx,
                                                      input logic [COORD_W-1:0] ty,
                                                      input logic [COORD_W-1:0] tz);
        longint             px, py, pz, lx, ly, lz;
        longint             xm, ym, zq, base_fx, deg;
        longint             theta [3];
        logic [ANGLE_W-1:0] ang [3];
        logic               out_of_servo;
        dpsa_result_t       r;
        px = longint'($signed(tx));
        py = longint'($signed(ty));
        pz = longint'($signed(tz));
        lx = longint'(lim_x);
        ly = longint'(lim_y);
        lz = longint'(lim_z);
        r = RANGE_FAULT;
        if (px < 0 || px > lx || py < 0 || py > ly || pz < 0 || pz > lz)
            return r;

        xm = grid_to_span(px, MM_SPAN_XY, lx) - MM_SHIFT;
        ym = grid_to_span(py, MM_SPAN_XY, ly) - MM_SHIFT;
        zq = grid_to_span(pz, MM_SPAN_Z, lz);
        base_fx = ((zq * BASE_DEG) / 100 + BASE_DEG) * FX_ONE;

        // Arms at 0, 120 and 240 degrees
        theta[0] = base_fx + xm * COEF_FIFTH;
        theta[1] = base_fx - xm * COEF_TENTH + ym * COEF_ROOT;
        theta[2] = base_fx - xm * COEF_TENTH - ym * COEF_ROOT;

        // Truncate toward zero, then clamp to the servo range
        out_of_servo = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            if (theta[i] < longint'(SERVO_LO) * FX_ONE ||
                theta[i] > longint'(SERVO_HI) * FX_ONE)
                out_of_servo = 1'b1;
            deg = theta[i] / FX_ONE;
            if (deg < SERVO_LO)
                deg = SERVO_LO;
            if (deg > SERVO_HI)
                deg = SERVO_HI;
            ang[i] = deg[ANGLE_W-1:0];
        end
        r.angle_one = ang[0];
        r.angle_two = ang[1];
        r.angle_three = ang[2];
        r.status = out_of_servo ? STATUS_SERVO : STATUS_OK;
        return r;
    endfunction

    // Coordinate for one axis: inside 0..lim, or some value that may fall outside
    function automatic logic [COORD_W-1:0] pick_coord(input logic [LIMIT_W-1:0] lim,
                                                      input bit in_range);
        logic [COORD_W-1:0] v;
        if (in_range)
        begin
            case ($urandom_range(9))
                0: v = '0;
                1: v = {1'b0, lim};
                default: v = COORD_W'($urandom_range(int'(lim)));
            endcase
        end
        else
        begin
            case ($urandom_range(3))
                0: v = 16'hFFFF;
                1: v = {1'b0, lim} + 16'd1;
                default: v = COORD_W'($urandom);
            endcase
        end
        return v;
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    // Present one target, hold it until accepted, record its expected angles
    task automatic send_target(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                               input logic [COORD_W-1:0] z, input logic typed,
                               input dpsa_result_t typed_res);
        if (!steady && $urandom_range(99) < 7)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {z, y, x};
        do
            @(posedge clk);
        while (!s_tready);
        pending_angles.push_back(typed ? typed_res : servo_angles_for(x, y, z));
    endtask

    // Stop sending and wait for every outstanding result beat
    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        while (pending_angles.size() != 0)
            @(posedge clk);
    endtask

    // Limit registers, written back to back while the unit is idle
    task automatic write_limits(input logic [LIMIT_W-1:0] lx, input logic [LIMIT_W-1:0] ly,
                                input logic [LIMIT_W-1:0] lz);
        cfg_wr_en <= 1'b1;
        cfg_addr <= REG_LIMIT_X;
        cfg_wdata <= lx;
        @(posedge clk);
        cfg_addr <= REG_LIMIT_Y;
        cfg_wdata <= ly;
        @(posedge clk);
        cfg_addr <= REG_LIMIT_Z;
        cfg_wdata <= lz;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        lim_x = lx;
        lim_y = ly;
        lim_z = lz;
    endtask

    // Result side back-pressure
    always @(posedge clk)
        m_tready <= steady || ($urandom_range(99) >= 7);

    // Result beat checker
    always @(posedge clk)
    begin
        dpsa_result_t got;
        dpsa_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = dpsa_result_t'(m_tdata[$bits(dpsa_result_t)-1:0]);
            if (pending_angles.size() == 0)
            begin
                $display("%0t ns: result beat mismatch, expected none, actual %0h",
                         $time, got);
                mismatches++;
            end
            else
            begin
                want = pending_angles.pop_front();
                check_field("status", int'(want.status), int'(got.status));
                check_field("angle_one", int'(want.angle_one), int'(got.angle_one));
                check_field("angle_two", int'(want.angle_two), int'(got.angle_two));
                check_field("angle_three", int'(want.angle_three), int'(got.angle_three));
            end
        end
    end

    // Watchdog on cycles with no beat on either side
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // Stimulus
    initial
    begin
        logic [LIMIT_W-1:0] lims [3];
        logic [COORD_W-1:0] coord [3];
        bit                 good;
        int                 bad_axis;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part under reset limits
        foreach (DIRECTED[i])
            send_target(DIRECTED[i].x, DIRECTED[i].y, DIRECTED[i].z,
                        DIRECTED[i].typed, DIRECTED[i].res);

        // Random part, one limit setting per phase
        for (int phase = 0; phase < PHASES; phase++)
        begin
            wait_results_drained();
            case (phase)
                0: lims = '{15'd1, 15'd1, 15'd1};
                1: lims = '{15'd32767, 15'd32767, 15'd32767};
                2: lims = '{15'd0, 15'd7, 15'd32767};      // zero limit on x
                3: lims = '{15'd32767, 15'd0, 15'd1};
                5: lims = '{LIMIT_W'($urandom_range(1, 300)), LIMIT_W'($urandom_range(1, 300)),
                            LIMIT_W'($urandom_range(1, 300))};
                default: lims = '{LIMIT_W'($urandom_range(1, 32767)),
                                  LIMIT_W'($urandom_range(1, 32767)),
                                  LIMIT_W'($urandom_range(1, 32767))};
            endcase
            write_limits(lims[0], lims[1], lims[2]);
            steady = (phase == 1);

            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                // in phase 5 the sender holds off once mid-phase until the pipe is empty
                if (phase == 5 && n == ITEMS_PER_PHASE / 2)
                    wait_results_drained();
                good = $urandom_range(99) < 85;
                bad_axis = $urandom_range(2);
                for (int a = 0; a < 3; a++)
                    coord[a] = pick_coord(lims[a], good || (a != bad_axis && $urandom_range(1)));
                send_target(coord[0], coord[1], coord[2], 1'b0, NOT_TYPED);
            end
        end
        steady = 1'b0;

        // Drain, then watch for stray beats
        wait_results_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending_angles.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
